// ===== rtl/core/mwsd_pkg.sv =====
// shared types and constants of the multichannel window sum detector
package mwsd_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int SAMPLE_W     = 8;
    localparam int SUM_W        = 12;
    localparam int CH_W         = 2;
    localparam int WLEN_W       = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 12;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 16;

    typedef logic [CH_W-1:0]        ch_t;
    typedef logic [SAMPLE_W-1:0]    sample_t;
    typedef logic [SUM_W-1:0]       sum_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // configuration register indexes
    localparam cfg_index_t REG_WINDOW_LENGTH    = 1'd0;
    localparam cfg_index_t REG_DETECT_THRESHOLD = 1'd1;

    // register reset values
    localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET    = 5'd3;
    localparam sum_t              DETECT_THRESHOLD_RESET = 12'd100;

    localparam ch_t LAST_CHANNEL = 2'(NUM_CHANNELS - 1);

endpackage

// ===== rtl/core/mwsd_ram.sv =====
// generic single-write, single-read ram with registered read data
module mwsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds its data while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/multichannel_window_sum_detector.sv =====
// top level of the round-robin moving window sum detector
//
// Samples arrive on the slave stream and are dealt to channels 0, 1, 2 in turn. Each channel
// keeps a ring of its RING_DEPTH newest samples in one shared ram; a running window sum per
// channel is updated by adding the new sample and subtracting the one that leaves the window,
// which the ram read of the accept cycle fetches. One transaction is accepted per clock while
// the output is not stalled and no rebuild runs; its result is loaded into the output register
// from the update stage (the ram read happens on the accept edge, the update when the update
// stage fires). The result gives the channel, its window sum, and a detect bit per channel (sum
// strictly above detect_threshold). Unwritten ring entries read as zero through per-entry valid
// bits, so there is no clearing pass after reset. A write to window_length starts a rebuild of
// all three sums from the rings: s_tready stays low while the rebuild runs (not at all for a
// length of zero). A threshold write takes effect at once.
module multichannel_window_sum_detector #(
    parameter int RING_DEPTH = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // slave stream: tdata = sample[7:0]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mwsd_pkg::IN_TDATA_W-1:0]  s_tdata,
    // master stream: tdata = window_sum[11:0], detect_flags[14:12], zero pad[15]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mwsd_pkg::OUT_TDATA_W-1:0] m_tdata,
    // master stream: tuser = channel[1:0]
    output logic [mwsd_pkg::CH_W-1:0]      m_tuser,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [mwsd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mwsd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import mwsd_pkg::*;

    localparam int SLOT_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LEN_W     = $clog2(RING_DEPTH + 1);
    localparam int MOD_W     = $clog2(2 * RING_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_CHANNELS * RING_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    localparam int MAX_SUM   = 255 * RING_DEPTH;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [LEN_W-1:0]  len_t;

    // ring address of a slot of a channel
    function automatic addr_t ring_addr(input ch_t ch, input slot_t slot);
        ring_addr = addr_t'(ADDR_W'(ch) * ADDR_W'(RING_DEPTH) + ADDR_W'(slot));
    endfunction

    // configuration registers
    logic [WLEN_W-1:0] window_length_reg;
    sum_t              detect_threshold_reg;

    // channel state
    slot_t write_slot_reg [NUM_CHANNELS];
    ch_t   next_channel_reg;
    sum_t  sums_reg [NUM_CHANNELS];
    logic [RAM_DEPTH-1:0] ring_valid_reg;

    // update stage
    logic    s1_valid_reg;
    ch_t     s1_ch_reg;
    slot_t   s1_slot_reg;
    sample_t s1_sample_reg;

    // rebuild sequencer
    logic  rc_active_reg;
    ch_t   rc_ch_reg;
    len_t  rc_idx_reg;
    logic  rc_pend_reg;
    ch_t   rc_pend_ch_reg;

    // ram read side
    logic    rd_valid_reg;
    sample_t rd_data;
    logic    ram_re;
    addr_t   ram_raddr;
    addr_t   s1_addr;

    // output register
    logic                   out_valid_reg;
    ch_t                    out_channel_reg;
    sum_t                   out_sum_reg;
    logic [NUM_CHANNELS-1:0] out_flags_reg;

    len_t    len_eff;
    slot_t   acc_slot;
    slot_t   lv_slot;
    logic [MOD_W-1:0] lv_tmp;
    slot_t   rc_slot;
    logic [MOD_W-1:0] rc_tmp;
    addr_t   acc_raddr;
    addr_t   rc_raddr;
    logic    s_fire;
    logic    s1_fire;
    logic    rc_last_idx;
    logic    wlen_write;
    sample_t leave_sample;
    logic [SUM_W:0] upd_sum;
    sum_t    new_sum;
    logic [NUM_CHANNELS-1:0] new_flags;
    sum_t    rc_add_sum;

    // effective window length, clamped to the ring depth
    always_comb
    begin
        if (window_length_reg > WLEN_W'(RING_DEPTH))
        begin
            len_eff = len_t'(RING_DEPTH);
        end
        else
        begin
            len_eff = len_t'(window_length_reg);
        end
    end

    // leaving slot of the accepted sample: write slot minus window length, modulo depth
    always_comb
    begin
        acc_slot = write_slot_reg[next_channel_reg];
        lv_tmp   = MOD_W'(acc_slot) + MOD_W'(RING_DEPTH) - MOD_W'(len_eff);
        if (lv_tmp >= MOD_W'(RING_DEPTH))
        begin
            lv_slot = slot_t'(lv_tmp - MOD_W'(RING_DEPTH));
        end
        else
        begin
            lv_slot = slot_t'(lv_tmp);
        end
        acc_raddr = ring_addr(next_channel_reg, lv_slot);
    end

    // rebuild read slot: newest minus index, modulo depth
    always_comb
    begin
        rc_tmp = MOD_W'(write_slot_reg[rc_ch_reg]) + MOD_W'(RING_DEPTH) - MOD_W'(1)
                 - MOD_W'(rc_idx_reg);
        if (rc_tmp >= MOD_W'(RING_DEPTH))
        begin
            rc_slot = slot_t'(rc_tmp - MOD_W'(RING_DEPTH));
        end
        else
        begin
            rc_slot = slot_t'(rc_tmp);
        end
        rc_raddr    = ring_addr(rc_ch_reg, rc_slot);
        rc_last_idx = ((rc_idx_reg + len_t'(1)) == len_eff);
    end

    // handshake and ram read selection
    assign s1_fire    = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !rc_active_reg && !rc_pend_reg && (!s1_valid_reg || s1_fire);
    assign s_fire     = s_tvalid && s_tready;
    assign ram_re     = s_fire || rc_active_reg;
    assign ram_raddr  = rc_active_reg ? rc_raddr : acc_raddr;
    assign s1_addr    = ring_addr(s1_ch_reg, s1_slot_reg);
    assign wlen_write = cfg_we && (cfg_index == REG_WINDOW_LENGTH);

    // incremental window sum update and detect flags
    always_comb
    begin
        leave_sample = rd_valid_reg ? rd_data : '0;
        upd_sum      = {1'b0, sums_reg[s1_ch_reg]} + (SUM_W+1)'(s1_sample_reg)
                       - (SUM_W+1)'(leave_sample);
        if (len_eff == '0)
        begin
            new_sum = '0;
        end
        else
        begin
            new_sum = upd_sum[SUM_W-1:0];
        end
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            if (ch_t'(c) == s1_ch_reg)
            begin
                new_flags[c] = (new_sum > detect_threshold_reg);
            end
            else
            begin
                new_flags[c] = (sums_reg[c] > detect_threshold_reg);
            end
        end
        rc_add_sum = sums_reg[rc_pend_ch_reg] + SUM_W'(leave_sample);
    end

    // ring storage
    mwsd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_addr),
        .wdata (s1_sample_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg    <= WINDOW_LENGTH_RESET;
            detect_threshold_reg <= DETECT_THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH:    window_length_reg    <= cfg_wdata[WLEN_W-1:0];
                REG_DETECT_THRESHOLD: detect_threshold_reg <= cfg_wdata[SUM_W-1:0];
                default: ;
            endcase
        end
    end

    // accept side: channel rotation, write slots, read valid tracking, update stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_channel_reg <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                write_slot_reg[c] <= '0;
            end
            rd_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_ch_reg     <= '0;
            s1_slot_reg   <= '0;
            s1_sample_reg <= '0;
        end
        else
        begin
            if (ram_re)
            begin
                rd_valid_reg <= ring_valid_reg[ram_raddr];
            end
            if (s_fire)
            begin
                s1_ch_reg     <= next_channel_reg;
                s1_slot_reg   <= acc_slot;
                s1_sample_reg <= s_tdata[SAMPLE_W-1:0];
                if (acc_slot == slot_t'(RING_DEPTH - 1))
                begin
                    write_slot_reg[next_channel_reg] <= '0;
                end
                else
                begin
                    write_slot_reg[next_channel_reg] <= acc_slot + slot_t'(1);
                end
                if (next_channel_reg == LAST_CHANNEL)
                begin
                    next_channel_reg <= '0;
                end
                else
                begin
                    next_channel_reg <= next_channel_reg + ch_t'(1);
                end
            end
            if (s_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // ring entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_valid_reg <= '0;
        end
        else if (s1_fire)
        begin
            ring_valid_reg[s1_addr] <= 1'b1;
        end
    end

    // window sums and rebuild sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                sums_reg[c] <= '0;
            end
            rc_active_reg  <= 1'b0;
            rc_ch_reg      <= '0;
            rc_idx_reg     <= '0;
            rc_pend_reg    <= 1'b0;
            rc_pend_ch_reg <= '0;
        end
        else
        begin
            if (wlen_write)
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    sums_reg[c] <= '0;
                end
                rc_active_reg <= (cfg_wdata[WLEN_W-1:0] != '0);
                rc_ch_reg     <= '0;
                rc_idx_reg    <= '0;
                rc_pend_reg   <= 1'b0;
            end
            else
            begin
                rc_pend_reg    <= rc_active_reg;
                rc_pend_ch_reg <= rc_ch_reg;
                if (s1_fire)
                begin
                    sums_reg[s1_ch_reg] <= new_sum;
                end
                else if (rc_pend_reg)
                begin
                    sums_reg[rc_pend_ch_reg] <= rc_add_sum;
                end
                if (rc_active_reg)
                begin
                    if (rc_last_idx)
                    begin
                        rc_idx_reg <= '0;
                        if (rc_ch_reg == LAST_CHANNEL)
                        begin
                            rc_active_reg <= 1'b0;
                            rc_ch_reg     <= '0;
                        end
                        else
                        begin
                            rc_ch_reg <= rc_ch_reg + ch_t'(1);
                        end
                    end
                    else
                    begin
                        rc_idx_reg <= rc_idx_reg + len_t'(1);
                    end
                end
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            out_channel_reg <= '0;
            out_sum_reg     <= '0;
            out_flags_reg   <= '0;
        end
        else
        begin
            if (s1_fire)
            begin
                out_valid_reg   <= 1'b1;
                out_channel_reg <= s1_ch_reg;
                out_sum_reg     <= new_sum;
                out_flags_reg   <= new_flags;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_flags_reg, out_sum_reg};
    assign m_tuser  = out_channel_reg;

    // no transaction accepted while the sums are being rebuilt
    assert property (@(posedge clk) disable iff (!rst_n)
        (rc_active_reg || rc_pend_reg) |-> !s_tready)
        else $error("input accepted during sum rebuild");

    // channel rotation never leaves the channel range
    assert property (@(posedge clk) disable iff (!rst_n)
        next_channel_reg != ch_t'(NUM_CHANNELS))
        else $error("channel pointer out of range");

    // a stalled update stage keeps its transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |=>
        (s1_valid_reg && $stable(s1_ch_reg) && $stable(s1_sample_reg)))
        else $error("update stage lost a stalled transaction");

    // an update always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> (out_valid_reg && out_channel_reg == $past(s1_ch_reg)))
        else $error("update did not reach the output register");

    // running sums stay within what the ring can hold
    assert property (@(posedge clk) disable iff (!rst_n)
        (sums_reg[0] <= SUM_W'(MAX_SUM)) && (sums_reg[1] <= SUM_W'(MAX_SUM))
        && (sums_reg[2] <= SUM_W'(MAX_SUM)))
        else $error("window sum out of range");

endmodule
